[sv/fit_pkg.sv]
// Shared types and constants for the farthest insertion tour block.
// Used by the controller, the datapath and the top level.
package fit_pkg;

   localparam int DIST_W     = 25;
   localparam int TP_W       = 5;
   localparam int RSP_DATA_W = 8;
   localparam int REQ_DATA_W = 32;
   localparam int IN_COORD_W = 16;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_D_START,
      OP_D_ROW,
      OP_D_ROWL,
      OP_D_NEXTROW,
      OP_D_RDJ,
      OP_D_DIFF,
      OP_D_SQ,
      OP_D_ROOT,
      OP_D_WR,
      OP_T_INIT,
      OP_F_START,
      OP_F_ISSUE,
      OP_F_DRAIN,
      OP_C_START,
      OP_C_RDNXT,
      OP_C_B,
      OP_C_AM,
      OP_C_MB,
      OP_C_AB,
      OP_C_CMP,
      OP_I_W1,
      OP_I_W2,
      OP_O_START,
      OP_O_EMIT,
      OP_O_ADV,
      OP_O_DONE
   } op_type;

   typedef struct packed {
      logic row_end;
      logic rows_done;
      logic f_last;
      logic root_busy;
      logic wrap;
      logic grow_done;
      logic single;
      logic out_last;
   } status_type;

endpackage

[sv/fit_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module fit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[sv/fit_sqrt.sv]
// Iterative floor square root, two radicand bits per cycle.
// No dependencies.
module fit_sqrt #(
   parameter int IN_W = 49
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [IN_W-1:0]      value,
   output logic                 busy,
   output logic [(IN_W+1)/2-1:0] root
);
   localparam int ITERS = (IN_W + 1) / 2;
   localparam int VW    = 2 * ITERS;
   localparam int RW    = ITERS + 3;
   localparam int SW    = $clog2(ITERS + 1);

   logic          busy_ff, busy_in;
   logic [SW-1:0] step_ff, step_in;
   logic [VW-1:0] val_ff, val_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [ITERS-1:0] root_ff, root_in;
   logic [RW-1:0] rem_sh, trial;
   logic          ge;

   assign rem_sh = {rem_ff[RW-3:0], val_ff[VW-1 -: 2]};
   assign trial  = RW'({root_ff, 2'b01});
   assign ge     = rem_sh >= trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = SW'(ITERS);
         val_in  = VW'(value);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in  = {val_ff[VW-3:0], 2'b00};
         rem_in  = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ITERS-2:0], ge};
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

[sv/fit_datapath.sv]
// Datapath: point, distance, nearest and link stores, counters and compares.
// Depends on fit_pkg, fit_ram and fit_sqrt.
module fit_datapath #(
   parameter int MAX_POINTS     = 32,
   parameter int COORD_BITS     = 16,
   parameter int DIST_FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fit_pkg::op_type                   op,
   input  logic [fit_pkg::REQ_DATA_W-1:0]    req_data,
   output fit_pkg::status_type               status,
   output logic [fit_pkg::TP_W-1:0]          rsp_point,
   output logic                              rsp_last,
   output logic                              rsp_drop
);
   import fit_pkg::*;

   localparam int PW    = $clog2(MAX_POINTS);
   localparam int CNTW  = $clog2(MAX_POINTS + 1);
   localparam int CW    = COORD_BITS;
   localparam int FULLW = 2 * CW + 1 + 2 * DIST_FRAC_BITS;
   localparam int SQW   = (FULLW > 64) ? 64 : FULLW;
   localparam int RTW   = (SQW + 1) / 2;
   localparam int DAW   = 2 * PW;
   localparam int COSTW = DIST_W + 2;

   function automatic logic [DAW-1:0] pair_addr(input logic [PW-1:0] a,
                                                input logic [PW-1:0] b);
      return (a >= b) ? {a, b} : {b, a};
   endfunction

   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            ovf_ff, ovf_in;
   logic [CNTW-1:0] ii_ff, ii_in, jj_ff, jj_in;
   logic [CW-1:0]   xi_ff, xi_in, yi_ff, yi_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [2*CW-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [MAX_POINTS-1:0] visited_ff, visited_in;
   logic [PW-1:0]   new_ff, new_in;
   logic [CNTW-1:0] size_ff, size_in;
   logic            first_ff, first_in;
   logic            p_vld_ff, p_vld_in;
   logic [PW-1:0]   p_i_ff, p_i_in;
   logic            found_ff, found_in;
   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [PW-1:0]   best_ff, best_in;
   logic [PW-1:0]   a_ff, a_in, b_ff, b_in;
   logic [DIST_W-1:0] dam_ff, dam_in, dmb_ff, dmb_in, dab_ff, dab_in;
   logic signed [COSTW-1:0] best_cost_ff, best_cost_in;
   logic [PW-1:0]   best_a_ff, best_a_in, best_b_ff, best_b_in;
   logic            pos_first_ff, pos_first_in;
   logic [PW-1:0]   cur_ff, cur_in;
   logic [CNTW-1:0] k_ff, k_in;
   logic [TP_W-1:0] rsp_point_ff, rsp_point_in;
   logic            rsp_last_ff, rsp_last_in, rsp_drop_ff, rsp_drop_in;

   logic [CW-1:0]     req_x, req_y, xj, yj;
   logic [2*CW-1:0]   xy_wdata, xy_q;
   logic              xy_we, xy_re;
   logic [PW-1:0]     xy_raddr;
   logic              d_we, d_re;
   logic [DAW-1:0]    d_waddr, d_raddr;
   logic [DIST_W-1:0] d_wdata, d_q;
   logic [DIST_W-1:0] near_q, nn;
   logic              nx_we, nx_re;
   logic [PW-1:0]     nx_waddr, nx_wdata, nx_raddr, nx_q;
   logic [2*CW:0]     sq_sum;
   logic [SQW-1:0]    sq_val;
   logic              root_busy;
   logic [RTW-1:0]    root;
   logic signed [COSTW-1:0] cost;

   assign req_x  = CW'(req_data[IN_COORD_W-1:0]);
   assign req_y  = CW'(req_data[2*IN_COORD_W-1:IN_COORD_W]);
   assign xj     = xy_q[CW-1:0];
   assign yj     = xy_q[2*CW-1:CW];
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sq_val = SQW'(FULLW'(sq_sum) << (2 * DIST_FRAC_BITS));
   assign nn     = (first_ff || d_q < near_q) ? d_q : near_q;
   assign cost   = $signed({2'b00, dam_ff}) + $signed({2'b00, dmb_ff})
                 - $signed({2'b00, dab_ff});

   // memory ports
   always_comb begin
      xy_we    = (op == OP_LOAD) && (cnt_ff < CNTW'(MAX_POINTS));
      xy_wdata = {req_y, req_x};
      xy_re    = (op == OP_D_ROW) || (op == OP_D_RDJ);
      xy_raddr = (op == OP_D_ROW) ? ii_ff[PW-1:0] : jj_ff[PW-1:0];

      d_we    = (op == OP_D_ROW) || (op == OP_D_WR);
      d_waddr = (op == OP_D_ROW) ? {ii_ff[PW-1:0], ii_ff[PW-1:0]}
                                 : {ii_ff[PW-1:0], jj_ff[PW-1:0]};
      d_wdata = (op == OP_D_ROW) ? '0 : DIST_W'(root);
      d_re    = 1'b0;
      d_raddr = '0;
      case (op)
         OP_F_ISSUE: begin
            d_re = 1'b1; d_raddr = pair_addr(ii_ff[PW-1:0], new_ff);
         end
         OP_C_B: begin
            d_re = 1'b1; d_raddr = pair_addr(a_ff, best_ff);
         end
         OP_C_AM: begin
            d_re = 1'b1; d_raddr = pair_addr(best_ff, b_ff);
         end
         OP_C_MB: begin
            d_re = 1'b1; d_raddr = pair_addr(a_ff, b_ff);
         end
         default: ;
      endcase

      nx_we    = 1'b0;
      nx_waddr = '0;
      nx_wdata = '0;
      case (op)
         OP_I_W1: begin
            nx_we = 1'b1; nx_waddr = best_ff; nx_wdata = best_b_ff;
         end
         OP_I_W2: begin
            nx_we = 1'b1; nx_waddr = best_a_ff; nx_wdata = best_ff;
         end
         OP_T_INIT: nx_we = 1'b1;
         default: ;
      endcase
      nx_re    = (op == OP_C_RDNXT) || (op == OP_O_EMIT);
      nx_raddr = (op == OP_O_EMIT) ? cur_ff : a_ff;
   end

   always_comb begin
      cnt_in = cnt_ff;  ovf_in = ovf_ff;
      ii_in = ii_ff;    jj_in = jj_ff;
      xi_in = xi_ff;    yi_in = yi_ff;   dx_in = dx_ff;   dy_in = dy_ff;
      sqx_in = sqx_ff;  sqy_in = sqy_ff;
      visited_in = visited_ff;
      new_in = new_ff;  size_in = size_ff; first_in = first_ff;
      p_vld_in = 1'b0;  p_i_in = p_i_ff;
      found_in = found_ff; best_d_in = best_d_ff; best_in = best_ff;
      a_in = a_ff;      b_in = b_ff;
      dam_in = dam_ff;  dmb_in = dmb_ff; dab_in = dab_ff;
      best_cost_in = best_cost_ff; best_a_in = best_a_ff; best_b_in = best_b_ff;
      pos_first_in = pos_first_ff;
      cur_in = cur_ff;  k_in = k_ff;
      rsp_point_in = rsp_point_ff; rsp_last_in = rsp_last_ff; rsp_drop_in = rsp_drop_ff;

      // farthest search: fold one nearest distance per cycle
      if (p_vld_ff && !visited_ff[p_i_ff] && (!found_ff || nn > best_d_ff)) begin
         found_in  = 1'b1;
         best_d_in = nn;
         best_in   = p_i_ff;
      end

      case (op)
         OP_LOAD: begin
            if (cnt_ff < CNTW'(MAX_POINTS)) cnt_in = cnt_ff + CNTW'(1);
            else                            ovf_in = 1'b1;
         end
         OP_D_START:   ii_in = '0;
         OP_D_ROWL: begin
            xi_in = xj; yi_in = yj; jj_in = '0;
         end
         OP_D_NEXTROW: ii_in = ii_ff + CNTW'(1);
         OP_D_DIFF: begin
            dx_in = (xi_ff > xj) ? xi_ff - xj : xj - xi_ff;
            dy_in = (yi_ff > yj) ? yi_ff - yj : yj - yi_ff;
         end
         OP_D_SQ: begin
            sqx_in = dx_ff * dx_ff;
            sqy_in = dy_ff * dy_ff;
         end
         OP_D_WR:      jj_in = jj_ff + CNTW'(1);
         OP_T_INIT: begin
            visited_in    = '0;
            visited_in[0] = 1'b1;
            new_in   = '0;
            size_in  = CNTW'(1);
            first_in = 1'b1;
         end
         OP_F_START: begin
            ii_in = '0; found_in = 1'b0;
         end
         OP_F_ISSUE: begin
            p_vld_in = 1'b1;
            p_i_in   = ii_ff[PW-1:0];
            ii_in    = ii_ff + CNTW'(1);
         end
         OP_C_START: begin
            first_in = 1'b0; a_in = '0; pos_first_in = 1'b1;
         end
         OP_C_B:  b_in = nx_q;
         OP_C_AM: dam_in = d_q;
         OP_C_MB: dmb_in = d_q;
         OP_C_AB: dab_in = d_q;
         OP_C_CMP: begin
            // earliest position wins a tie
            if (pos_first_ff || cost < best_cost_ff) begin
               best_cost_in = cost;
               best_a_in    = a_ff;
               best_b_in    = b_ff;
            end
            pos_first_in = 1'b0;
            a_in = b_ff;
         end
         OP_I_W2: begin
            visited_in[best_ff] = 1'b1;
            new_in  = best_ff;
            size_in = size_ff + CNTW'(1);
         end
         OP_O_START: begin
            cur_in = '0; k_in = '0;
         end
         OP_O_EMIT: begin
            rsp_point_in = TP_W'(cur_ff);
            rsp_last_in  = (k_ff == cnt_ff);
            rsp_drop_in  = ovf_ff;
         end
         OP_O_ADV: begin
            cur_in = nx_q; k_in = k_ff + CNTW'(1);
         end
         OP_O_DONE: begin
            cnt_in = '0; ovf_in = 1'b0; visited_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         visited_ff <= '0;
         p_vld_ff   <= 1'b0;
         found_ff   <= 1'b0;
         first_ff   <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         visited_ff <= visited_in;
         p_vld_ff   <= p_vld_in;
         found_ff   <= found_in;
         first_ff   <= first_in;
      end
      ii_ff <= ii_in;   jj_ff <= jj_in;
      xi_ff <= xi_in;   yi_ff <= yi_in;   dx_ff <= dx_in;   dy_ff <= dy_in;
      sqx_ff <= sqx_in; sqy_ff <= sqy_in;
      new_ff <= new_in; size_ff <= size_in;
      p_i_ff <= p_i_in; best_d_ff <= best_d_in; best_ff <= best_in;
      a_ff <= a_in;     b_ff <= b_in;
      dam_ff <= dam_in; dmb_ff <= dmb_in; dab_ff <= dab_in;
      best_cost_ff <= best_cost_in; best_a_ff <= best_a_in; best_b_ff <= best_b_in;
      pos_first_ff <= pos_first_in;
      cur_ff <= cur_in; k_ff <= k_in;
      rsp_point_ff <= rsp_point_in; rsp_last_ff <= rsp_last_in; rsp_drop_ff <= rsp_drop_in;
   end

   fit_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_xy_ram (
      .clock(clock), .we(xy_we), .waddr(cnt_ff[PW-1:0]), .wdata(xy_wdata),
      .re(xy_re), .raddr(xy_raddr), .rdata(xy_q)
   );

   fit_ram #(.WIDTH(DIST_W), .DEPTH(1 << DAW)) u_dist_ram (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .re(d_re), .raddr(d_raddr), .rdata(d_q)
   );

   fit_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_near_ram (
      .clock(clock), .we(p_vld_ff), .waddr(p_i_ff), .wdata(nn),
      .re(op == OP_F_ISSUE), .raddr(ii_ff[PW-1:0]), .rdata(near_q)
   );

   fit_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_next_ram (
      .clock(clock), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
      .re(nx_re), .raddr(nx_raddr), .rdata(nx_q)
   );

   fit_sqrt #(.IN_W(SQW)) u_sqrt (
      .clock(clock), .reset(reset), .start(op == OP_D_ROOT), .value(sq_val),
      .busy(root_busy), .root(root)
   );

   always_comb begin
      status.row_end   = (jj_ff == ii_ff);
      status.rows_done = (ii_ff == cnt_ff);
      status.f_last    = (ii_ff + CNTW'(1) == cnt_ff);
      status.root_busy = root_busy;
      status.wrap      = (b_ff == '0);
      status.grow_done = (size_ff + CNTW'(1) == cnt_ff);
      status.single    = (cnt_ff == CNTW'(1));
      status.out_last  = (k_ff == cnt_ff);
   end

   assign rsp_point = rsp_point_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_drop  = rsp_drop_ff;
endmodule

[sv/fit_ctrl.sv]
// Controller: sequences loading, distance build, insertion rounds and output.
// Depends on fit_pkg.
module fit_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  fit_pkg::status_type status,
   output fit_pkg::op_type     op
);
   import fit_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_D_START, ST_D_ROW, ST_D_ROWL, ST_D_CHK, ST_D_NEXTROW, ST_D_RCHK,
      ST_D_PAIR, ST_D_DIFF, ST_D_SQ, ST_D_ROOTS, ST_D_ROOT, ST_D_WR,
      ST_T_INIT, ST_F_START, ST_F_RUN, ST_F_DRAIN,
      ST_C_START, ST_C_RDNXT, ST_C_B, ST_C_AM, ST_C_MB, ST_C_AB, ST_C_CMP,
      ST_I_W1, ST_I_W2, ST_O_START, ST_O_EMIT, ST_O_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, valid_ff;

   always_comb begin
      state_in = state_ff;
      op       = OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               op = OP_LOAD;
               if (req_tlast) state_in = ST_D_START;
            end
         end
         ST_D_START:   begin op = OP_D_START; state_in = ST_D_ROW; end
         ST_D_ROW:     begin op = OP_D_ROW; state_in = ST_D_ROWL; end
         ST_D_ROWL:    begin op = OP_D_ROWL; state_in = ST_D_CHK; end
         ST_D_CHK:     state_in = status.row_end ? ST_D_NEXTROW : ST_D_PAIR;
         ST_D_NEXTROW: begin op = OP_D_NEXTROW; state_in = ST_D_RCHK; end
         ST_D_RCHK:    state_in = status.rows_done ? ST_T_INIT : ST_D_ROW;
         ST_D_PAIR:    begin op = OP_D_RDJ; state_in = ST_D_DIFF; end
         ST_D_DIFF:    begin op = OP_D_DIFF; state_in = ST_D_SQ; end
         ST_D_SQ:      begin op = OP_D_SQ; state_in = ST_D_ROOTS; end
         ST_D_ROOTS:   begin op = OP_D_ROOT; state_in = ST_D_ROOT; end
         ST_D_ROOT:    if (!status.root_busy) state_in = ST_D_WR;
         ST_D_WR:      begin op = OP_D_WR; state_in = ST_D_CHK; end
         ST_T_INIT: begin
            op = OP_T_INIT;
            state_in = status.single ? ST_O_START : ST_F_START;
         end
         ST_F_START:   begin op = OP_F_START; state_in = ST_F_RUN; end
         ST_F_RUN: begin
            op = OP_F_ISSUE;
            if (status.f_last) state_in = ST_F_DRAIN;
         end
         ST_F_DRAIN:   begin op = OP_F_DRAIN; state_in = ST_C_START; end
         ST_C_START:   begin op = OP_C_START; state_in = ST_C_RDNXT; end
         ST_C_RDNXT:   begin op = OP_C_RDNXT; state_in = ST_C_B; end
         ST_C_B:       begin op = OP_C_B; state_in = ST_C_AM; end
         ST_C_AM:      begin op = OP_C_AM; state_in = ST_C_MB; end
         ST_C_MB:      begin op = OP_C_MB; state_in = ST_C_AB; end
         ST_C_AB:      begin op = OP_C_AB; state_in = ST_C_CMP; end
         ST_C_CMP: begin
            op = OP_C_CMP;
            state_in = status.wrap ? ST_I_W1 : ST_C_RDNXT;
         end
         ST_I_W1:      begin op = OP_I_W1; state_in = ST_I_W2; end
         ST_I_W2: begin
            op = OP_I_W2;
            state_in = status.grow_done ? ST_O_START : ST_F_START;
         end
         ST_O_START:   begin op = OP_O_START; state_in = ST_O_EMIT; end
         ST_O_EMIT:    begin op = OP_O_EMIT; state_in = ST_O_WAIT; end
         ST_O_WAIT: begin
            if (rsp_tready) begin
               if (status.out_last) begin
                  op = OP_O_DONE; state_in = ST_IDLE;
               end else begin
                  op = OP_O_ADV; state_in = ST_O_EMIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
         valid_ff <= (state_in == ST_O_WAIT);
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;
endmodule

[sv/farthest_insertion_tour_core.sv]
// Top level of the farthest insertion tour block.
// Depends on fit_pkg, fit_ctrl and fit_datapath.
//
// Usage: stream points in on the req_ channel, one word per point, and mark
// the final point with req_tlast. Points beyond MAX_POINTS are discarded and
// flagged on rsp_tuser of every result of the set. After the final point the
// block computes and then sends the tour on the rsp_ channel: point 0, the
// inserted points in tour order, and point 0 again with rsp_tlast high.
// Each word is accepted when req_tvalid and req_tready are both high. The final
// word starts the build of the distance store, one pair at a time through the
// shared square root unit (SQW = 2*COORD_BITS+1+2*DIST_FRAC_BITS, at most 64),
// then the insertion rounds, each a pass over all points and a walk of the
// tour over the distance memory port, then the output, where each result word
// is registered and then held until it is taken.
// One set is worked on at a time: req_tready is low from the final word until
// the closing result is taken. A stalled result is held until rsp_tready.
// Reset clears the point count, the overflow flag and the visited marks.
module farthest_insertion_tour_core #(
   parameter int MAX_POINTS     = 32,
   parameter int COORD_BITS     = 16,
   parameter int DIST_FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fit_pkg::REQ_DATA_W-1:0]     req_tdata,  // x_coord, y_coord
   input  logic                               req_tlast,  // last_point
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fit_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // tour_point, zero fill
   output logic                               rsp_tlast,  // last_of_tour
   output logic                               rsp_tuser   // dropped_points
);
   import fit_pkg::*;

   op_type          op;
   status_type      status;
   logic [TP_W-1:0] rsp_point;

   fit_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tlast(req_tlast), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .op(op)
   );

   fit_datapath #(
      .MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS),
      .DIST_FRAC_BITS(DIST_FRAC_BITS)
   ) u_datapath (
      .clock(clock), .reset(reset), .op(op), .req_data(req_tdata),
      .status(status), .rsp_point(rsp_point), .rsp_last(rsp_tlast),
      .rsp_drop(rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - TP_W){1'b0}}, rsp_point};
endmodule

[sv/fit_checker.sv]
// Port-level checks for the farthest insertion tour block, bound to the top.
// Depends on farthest_insertion_tour_core's port list only.
module fit_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |-> rsp_tdata == 8'd0)
      else $error("tour does not close at point 0");

   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("block not idle after closing word");
endmodule

bind farthest_insertion_tour_core fit_checker u_fit_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
